@@ design/u8d_pkg.sv @@
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned LEFT_W = 2;

    // byte class tags, compared against the top bits of a byte
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // declared sequence lengths
    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // continuation bytes still expected
    localparam logic [LEFT_W-1:0] LEFT_IDLE  = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE   = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

    typedef struct packed {
        logic [LEFT_W-1:0] bytes_left;
        logic [CP_W-1:0]   partial_value;
        logic [LEN_W-1:0]  sequence_length;
    } t_dec_state;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             error;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result res;
    } t_step_out;

endpackage

@@ design/u8d_stream_if.sv @@
// handshake channels for input bytes and decoded code points
interface u8d_byte_if;
    logic                      valid;
    logic                      ready;
    logic [u8d_pkg::BYTE_W-1:0] data_byte;
    logic                      end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8d_cp_if;
    logic                      valid;
    logic                      ready;
    logic [u8d_pkg::CP_W-1:0]  code_point;
    logic [u8d_pkg::LEN_W-1:0] seq_length;
    logic                      error;

    modport source (output valid, output code_point, output seq_length, output error,
                    input ready);
    modport sink   (input valid, input code_point, input seq_length, input error,
                    output ready);
endinterface

@@ design/u8d_step.sv @@
// one decode step: next decoder state and optional result for one byte
module u8d_step (
    input  u8d_pkg::t_dec_state            i_state,
    input  logic [u8d_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_end_of_string,
    output u8d_pkg::t_dec_state            o_state,
    output u8d_pkg::t_step_out             o_out
);
    import u8d_pkg::*;

    t_dec_state          idle_state;
    t_dec_state          lead_state;
    logic                lead_ok;
    logic [LEFT_W-1:0]   left_dec;
    logic [CP_W-1:0]     shifted;

    assign idle_state = '{bytes_left: LEFT_IDLE, partial_value: '0, sequence_length: LEN_NONE};
    assign left_dec   = LEFT_W'(i_state.bytes_left - LEFT_ONE);
    assign shifted    = {i_state.partial_value[CP_W-7:0], i_data_byte[5:0]};

    // lead byte classification
    always_comb begin
        lead_ok    = 1'b1;
        lead_state = idle_state;
        if (i_data_byte[7:5] == LEAD2_TAG) begin
            lead_state = '{bytes_left: LEFT_ONE,
                           partial_value: CP_W'(i_data_byte[4:0]),
                           sequence_length: LEN_TWO};
        end else if (i_data_byte[7:4] == LEAD3_TAG) begin
            lead_state = '{bytes_left: LEFT_TWO,
                           partial_value: CP_W'(i_data_byte[3:0]),
                           sequence_length: LEN_THREE};
        end else if (i_data_byte[7:3] == LEAD4_TAG) begin
            lead_state = '{bytes_left: LEFT_THREE,
                           partial_value: CP_W'(i_data_byte[2:0]),
                           sequence_length: LEN_FOUR};
        end else begin
            lead_ok = 1'b0;
        end
    end

    always_comb begin
        o_state = idle_state;
        o_out   = '{emit: 1'b0, res: '{code_point: '0, seq_length: LEN_NONE, error: 1'b0}};
        if (i_state.bytes_left == LEFT_IDLE) begin
            if (!i_data_byte[7]) begin
                o_out = '{emit: 1'b1,
                          res: '{code_point: CP_W'(i_data_byte), seq_length: LEN_ONE,
                                 error: 1'b0}};
            end else if (!lead_ok) begin
                o_out = '{emit: 1'b1,
                          res: '{code_point: '0, seq_length: LEN_NONE, error: 1'b1}};
            end else if (i_end_of_string) begin
                // multi-byte lead that is itself the last byte
                o_out = '{emit: 1'b1,
                          res: '{code_point: '0, seq_length: lead_state.sequence_length,
                                 error: 1'b1}};
            end else begin
                o_state = lead_state;
            end
        end else if (i_data_byte[7:6] != CONT_TAG) begin
            o_out = '{emit: 1'b1,
                      res: '{code_point: '0, seq_length: i_state.sequence_length,
                             error: 1'b1}};
        end else if (left_dec == LEFT_IDLE) begin
            o_out = '{emit: 1'b1,
                      res: '{code_point: shifted, seq_length: i_state.sequence_length,
                             error: 1'b0}};
        end else if (i_end_of_string) begin
            o_out = '{emit: 1'b1,
                      res: '{code_point: '0, seq_length: i_state.sequence_length,
                             error: 1'b1}};
        end else begin
            o_state = '{bytes_left: left_dec, partial_value: shifted,
                        sequence_length: i_state.sequence_length};
        end
    end

endmodule

@@ design/utf8_stream_decoder.sv @@
// utf-8 stream decoder top level: input register, decode step, result register
// Takes one byte per beat and gives one code point beat for each finished sequence,
// or an error beat for a bad lead byte, a bad continuation byte or a sequence cut
// off by end of string. A byte is accepted every cycle as long as results are taken;
// a result beat is offered from the result register (the decode step works on the
// byte while it sits in the input register, and the result register loads it once
// it is free). The rate is set by the update of the decoder state from one
// registered byte. A result beat that is not taken holds the input register, so a
// held byte stalls the input in the same cycle as the output stalls.
// Bytes that only extend a sequence give no result beat.
module utf8_stream_decoder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    u8d_byte_if.sink i_byte,
    u8d_cp_if.source o_cp
);
    import u8d_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eos;
    t_dec_state        r_state;
    t_dec_state        n_state;
    logic              r_out_valid;
    t_result           r_out;
    t_step_out         step_out;
    logic              out_free;
    logic              in_ready;

    // result register can take a new value
    assign out_free = !r_out_valid || o_cp.ready;
    assign in_ready = !r_in_valid || out_free;

    assign i_byte.ready = in_ready;

    u8d_step u_step (
        .i_state         (r_state),
        .i_data_byte     (r_in_byte),
        .i_end_of_string (r_in_eos),
        .o_state         (n_state),
        .o_out           (step_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{bytes_left: LEFT_IDLE, partial_value: '0,
                             sequence_length: LEN_NONE};
        end else begin
            if (in_ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid && step_out.emit;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_eos  <= i_byte.end_of_string;
        end
        if (out_free && r_in_valid && step_out.emit) begin
            r_out <= step_out.res;
        end
    end

    assign o_cp.valid      = r_out_valid;
    assign o_cp.code_point = r_out.code_point;
    assign o_cp.seq_length = r_out.seq_length;
    assign o_cp.error      = r_out.error;

    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error |-> r_out.code_point == '0)
        else $error("error beat with nonzero code point");

    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.error |-> r_out.seq_length != LEN_NONE &&
                                        r_out.seq_length <= LEN_FOUR)
        else $error("good beat with bad length");

    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.seq_length == LEN_ONE |->
            !r_out.error && r_out.code_point[CP_W-1:7] == '0)
        else $error("one-byte beat out of ascii range");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_left == LEFT_IDLE |->
            r_state.partial_value == '0 && r_state.sequence_length == LEN_NONE)
        else $error("idle decoder holds stale state");

    a_left_vs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_left != LEFT_IDLE |->
            r_state.sequence_length > LEN_W'(r_state.bytes_left) &&
            r_state.sequence_length <= LEN_FOUR)
        else $error("bytes left inconsistent with sequence length");

endmodule
